// ===== src/tlgr_pkg.sv =====
// Shared types, register codes and the 5x8 column font of the status-line
// character generator. No dependencies; every file but tlgr_checker imports this package.

package tlgr_pkg;

	// Signed width for all horizontal and vertical coordinate arithmetic.
	localparam int COORD_W = 14;

	// Text memory geometry: four words of eight characters, the last holding seven.
	localparam int TEXT_WORDS = 4;
	localparam int WORD_ADDR_W = 2;
	localparam int TEXT_DATA_W = 64;
	localparam logic [TEXT_DATA_W-1:0] LAST_WORD_MASK = 64'h00ff_ffff_ffff_ffff;

	// Configuration register indexes.
	localparam logic [2:0] REG_TEXT_0_7 = 3'd0;
	localparam logic [2:0] REG_TEXT_8_15 = 3'd1;
	localparam logic [2:0] REG_TEXT_16_23 = 3'd2;
	localparam logic [2:0] REG_TEXT_24_30 = 3'd3;
	localparam logic [2:0] REG_TEXT_LENGTH = 3'd4;
	localparam logic [2:0] REG_INK_COLOR = 3'd5;
	localparam logic [2:0] REG_SCALE = 3'd6;

	// Reset values of the plain registers.
	localparam logic [15:0] INK_RESET = 16'hffff;
	localparam logic [7:0] SCALE_RESET = 8'd2;
	localparam logic [7:0] SCALE_ONE = 8'd1;

	// Character codes that bound the font coverage.
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_PERIOD = 8'h2e;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;

	// Font glyph slots for the capitals and the punctuation marks.
	localparam logic [5:0] GLYPH_UPPER_BASE = 6'd10;
	localparam logic [5:0] GLYPH_PERIOD = 6'd36;
	localparam logic [5:0] GLYPH_COMMA = 6'd37;
	localparam logic [5:0] GLYPH_MINUS = 6'd38;
	localparam logic [5:0] GLYPH_SLASH = 6'd39;
	localparam logic [5:0] GLYPH_COLON = 6'd40;
	localparam int GLYPH_COUNT = 41;
	localparam logic [2:0] GLYPH_LAST_COL = 3'd4;

	// Position of one pixel inside the text, as found by the address stage.
	typedef struct packed {
		logic hit;
		logic [WORD_ADDR_W-1:0] word;
		logic [2:0] byte_sel;
		logic [2:0] col;
		logic [2:0] row;
	} pix_loc_t;

	// One glyph per entry, column 0 in the low byte, row 0 in bit 0 of each column.
	localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
		40'h3e4549513e, 40'h00407f4200, 40'h4649516142, 40'h314b454121,
		40'h107f121418, 40'h3945454527, 40'h3049494a3c, 40'h0305097101,
		40'h3649494936, 40'h1e29494906, 40'h7e1111117e, 40'h364949497f,
		40'h224141413e, 40'h1c2241417f, 40'h414949497f, 40'h010909097f,
		40'h7a4949413e, 40'h7f0808087f, 40'h00417f4100, 40'h013f414020,
		40'h412214087f, 40'h404040407f, 40'h7f020c027f, 40'h7f1008047f,
		40'h3e4141413e, 40'h060909097f, 40'h5e2151413e, 40'h462919097f,
		40'h3149494946, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
		40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h4345495161,
		40'h0000606000, 40'h0000608000, 40'h0808080808, 40'h0204081020,
		40'h0000363600
	};

	// Column byte of a character's glyph; blank for characters outside the font.
	function automatic logic [7:0] glyph_column(input logic [7:0] ch, input logic [2:0] col);
		logic [5:0] idx;
		logic known;
		logic [39:0] glyph;
		idx = '0;
		known = 1'b1;
		if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			idx = 6'(ch - CH_DIGIT_0);
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			idx = GLYPH_UPPER_BASE + 6'(ch - CH_UPPER_A);
		end else if (ch == CH_PERIOD) begin
			idx = GLYPH_PERIOD;
		end else if (ch == CH_COMMA) begin
			idx = GLYPH_COMMA;
		end else if (ch == CH_MINUS) begin
			idx = GLYPH_MINUS;
		end else if (ch == CH_SLASH) begin
			idx = GLYPH_SLASH;
		end else if (ch == CH_COLON) begin
			idx = GLYPH_COLON;
		end else begin
			known = 1'b0;
		end
		glyph = FONT_ROM[idx];
		if (!known || col > GLYPH_LAST_COL) begin
			return 8'h00;
		end
		return glyph[{col, 3'b000} +: 8];
	endfunction

endpackage

// ===== src/tlgr_text_mem.sv =====
// Text memory of the character generator: four 64-bit words written from the
// configuration port, one registered read per cycle. Depends on tlgr_pkg.

module tlgr_text_mem (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [tlgr_pkg::WORD_ADDR_W-1:0] wr_addr,
	input  logic [tlgr_pkg::TEXT_DATA_W-1:0] wr_data,
	input  logic rd_en,
	input  logic [tlgr_pkg::WORD_ADDR_W-1:0] rd_addr,
	output logic [tlgr_pkg::TEXT_DATA_W-1:0] rd_data
);
	import tlgr_pkg::*;

	logic [TEXT_DATA_W-1:0] mem [TEXT_WORDS];
	logic [TEXT_WORDS-1:0] valid_q;
	logic [TEXT_DATA_W-1:0] rd_word_q;
	logic rd_valid_q;

	// Write port; the last word holds only seven characters.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_addr == WORD_ADDR_W'(TEXT_WORDS - 1)) begin
				mem[wr_addr] <= wr_data & LAST_WORD_MASK;
			end else begin
				mem[wr_addr] <= wr_data;
			end
		end
	end

	// A word never written since reset reads as blank text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

// ===== src/tlgr_pix_map.sv =====
// Address stage of the character generator: maps a pixel coordinate to the
// character, glyph column and glyph row it falls on. Depends on tlgr_pkg.

module tlgr_pix_map #(
	parameter int LINE_WIDTH = 224,
	parameter int LINE_HEIGHT = 16
) (
	input  logic [7:0] pixel_x,
	input  logic [3:0] pixel_y,
	input  logic [4:0] text_len,
	input  logic scale_one,
	output tlgr_pkg::pix_loc_t loc
);
	import tlgr_pkg::*;

	logic [9:0] len6;
	logic signed [COORD_W-1:0] text_w;
	logic signed [COORD_W-1:0] glyph_h;
	logic signed [COORD_W-1:0] x_diff;
	logic signed [COORD_W-1:0] x_diff_adj;
	logic signed [COORD_W-1:0] x0;
	logic signed [COORD_W-1:0] y0;
	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic signed [COORD_W-1:0] dx;
	logic signed [COORD_W-1:0] dy;
	logic on_line;
	logic in_text;
	logic [8:0] u;
	logic [16:0] pos_prod;
	logic [4:0] pos;
	logic [8:0] pos6;
	logic [8:0] col_full;

	// Text extent and the centered origin; the halving truncates toward zero.
	always_comb begin
		len6 = 10'({text_len, 2'b00}) + 10'({text_len, 1'b0});
		text_w = scale_one ? COORD_W'(len6) : COORD_W'({len6, 1'b0});
		glyph_h = scale_one ? COORD_W'(8) : COORD_W'(16);
		x_diff = COORD_W'(LINE_WIDTH) - text_w;
		x_diff_adj = x_diff + COORD_W'(x_diff[COORD_W-1]);
		x0 = x_diff_adj >>> 1;
		y0 = (COORD_W'(LINE_HEIGHT) - glyph_h) >>> 1;
	end

	// Offset of the pixel from the text origin and the range checks.
	always_comb begin
		px = COORD_W'(pixel_x);
		py = COORD_W'(pixel_y);
		dx = px - x0;
		dy = py - y0;
		on_line = (px < COORD_W'(LINE_WIDTH)) && (py < COORD_W'(LINE_HEIGHT));
		in_text = !dx[COORD_W-1] && (dx < text_w) && !dy[COORD_W-1] && (dy < glyph_h);
	end

	// Character index by reciprocal multiply: floor(u * 171 / 1024) equals u / 6
	// for every offset that lies inside a line of up to 31 characters.
	always_comb begin
		u = scale_one ? dx[8:0] : dx[9:1];
		pos_prod = 17'(u) * 17'd171;
		pos = pos_prod[14:10];
		pos6 = {2'b00, pos, 2'b00} + {3'b000, pos, 1'b0};
		col_full = u - pos6;
	end

	assign loc.hit = on_line && in_text;
	assign loc.word = pos[4:3];
	assign loc.byte_sel = pos[2:0];
	assign loc.col = col_full[2:0];
	assign loc.row = scale_one ? dy[2:0] : dy[3:1];

endmodule

// ===== src/text_line_glyph_rasterizer_unit.sv =====
// Pipeline: stage 1 registers the pixel location beside the text memory read,
// the output register takes the glyph lookup. Throughput: one pixel per clock
// while m_axis_tready does not stall the output; each stage holds one pixel.
// Reset: arst_n clears all valid flags, the text memory reads blank, length 0,
// ink color white and scale 2x; there is no clearing pass.
// Depends on tlgr_pkg, tlgr_pix_map and tlgr_text_mem.

module text_line_glyph_rasterizer_unit #(
	parameter int LINE_WIDTH = 224,
	parameter int LINE_HEIGHT = 16,
	parameter int MAX_CHARS = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: pixel_x[7:0], pixel_y[11:8], zero pad [15:12].
	input  logic [15:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0: pixel_color[15:0], pixel_lit[16], zero pad [23:17].
	output logic [23:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);
	import tlgr_pkg::*;

	logic [4:0] text_length_q;
	logic [15:0] ink_color_q;
	logic [7:0] scale_select_q;
	logic [4:0] eff_len;
	logic scale_one;
	pix_loc_t loc;
	pix_loc_t loc_s1;
	logic v_s1;
	logic out_valid_q;
	logic [15:0] color_q;
	logic lit_q;
	logic out_adv;
	logic s1_load;
	logic text_wr;
	logic [TEXT_DATA_W-1:0] text_word;
	logic [7:0] ch;
	logic [7:0] col_bits;
	logic lit;

	// Configuration registers other than the text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q <= '0;
			ink_color_q <= INK_RESET;
			scale_select_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_LENGTH: text_length_q <= cfg_data[4:0];
				REG_INK_COLOR: ink_color_q <= cfg_data[15:0];
				REG_SCALE: scale_select_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign text_wr = cfg_we && (cfg_index <= REG_TEXT_24_30);
	assign eff_len = (text_length_q > 5'(MAX_CHARS)) ? 5'(MAX_CHARS) : text_length_q;
	assign scale_one = (scale_select_q == SCALE_ONE);

	// Pipeline control: the output register frees stage 1, stage 1 frees the input.
	assign out_adv = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !v_s1 || out_adv;
	assign s1_load = s_axis_tready;

	tlgr_pix_map #(
		.LINE_WIDTH(LINE_WIDTH),
		.LINE_HEIGHT(LINE_HEIGHT)
	) u_pix_map (
		.pixel_x(s_axis_tdata[7:0]),
		.pixel_y(s_axis_tdata[11:8]),
		.text_len(eff_len),
		.scale_one(scale_one),
		.loc(loc)
	);

	tlgr_text_mem u_text_mem (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(text_wr),
		.wr_addr(cfg_index[WORD_ADDR_W-1:0]),
		.wr_data(cfg_data),
		.rd_en(s1_load),
		.rd_addr(loc.word),
		.rd_data(text_word)
	);

	// Stage 1: pixel location, aligned with the text memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_load) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			loc_s1 <= loc;
		end
	end

	// Glyph lookup on the character read from memory.
	always_comb begin
		ch = text_word[{loc_s1.byte_sel, 3'b000} +: 8];
		col_bits = glyph_column(ch, loc_s1.col);
		lit = loc_s1.hit && col_bits[loc_s1.row];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			lit_q <= lit;
			color_q <= lit ? ink_color_q : 16'h0000;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'b0000000, lit_q, color_q};

endmodule

// ===== src/tlgr_checker.sv =====
// Port-level checker for the character generator output stream, bound to the
// top level. Depends on nothing but the top level's ports.

module tlgr_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tready,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [23:0] m_axis_tdata
);

	// An unlit pixel is always black.
	a_unlit_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'h0000)
		else $error("unlit pixel carries a nonzero color");

	// The pad bits above pixel_lit stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:17] == 7'b0000000)
		else $error("output pad bits are not zero");

	// With the output register empty the block takes input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output is empty");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output transaction changed");

endmodule

bind text_line_glyph_rasterizer_unit tlgr_checker u_tlgr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

// ===== dv/tb.sv =====
// Self-checking bench for the status-line character generator: drives pixel
// coordinates under many text, color and scale settings and checks every pixel.
// Depends on tlgr_pkg and on the text_line_glyph_rasterizer_unit RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlgr_pkg::*;

	localparam int LINE_W = 224;
	localparam int LINE_H = 16;
	localparam int MAX_CHARS = 31;
	localparam int PIPE_LATENCY = 2;
	localparam int CONFIG_PHASES = 30;
	localparam int PIXELS_PER_PHASE = 50;
	// Register index with no register behind it.
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	// Expected content of one output transaction.
	typedef struct packed {
		logic [15:0] color;
		logic lit;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Bench copy of the configuration registers.
	logic [63:0] text_word [TEXT_WORDS];
	logic [4:0] text_len;
	logic [15:0] ink;
	logic [7:0] scale_sel;

	// Characters staged for the next text load.
	logic [7:0] line_text [MAX_CHARS];

	logic [15:0] pending_pixels[$];
	pixel_result_t expected_pixels[$];
	int error_count = 0;
	int src_idle_pct = 17;
	int snk_idle_pct = 67;

	text_line_glyph_rasterizer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Column byte of a character's glyph, row 0 in bit 0; blank outside the font.
	function automatic logic [7:0] font_column(input logic [7:0] ch, input int col);
		int idx;
		logic [39:0] g;
		idx = -1;
		g = '0;
		if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			idx = int'(ch - CH_DIGIT_0);
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			idx = 10 + int'(ch - CH_UPPER_A);
		end else if (ch == CH_PERIOD) begin
			idx = 36;
		end else if (ch == CH_COMMA) begin
			idx = 37;
		end else if (ch == CH_MINUS) begin
			idx = 38;
		end else if (ch == CH_SLASH) begin
			idx = 39;
		end else if (ch == CH_COLON) begin
			idx = 40;
		end
		if (idx < 0 || col > 4) begin
			return 8'h00;
		end
		// Column 0 sits in the top byte of each entry.
		case (idx)
			0: g = 40'h3e5149453e;
			1: g = 40'h00427f4000;
			2: g = 40'h4261514946;
			3: g = 40'h2141454b31;
			4: g = 40'h1814127f10;
			5: g = 40'h2745454539;
			6: g = 40'h3c4a494930;
			7: g = 40'h0171090503;
			8: g = 40'h3649494936;
			9: g = 40'h064949291e;
			10: g = 40'h7e1111117e;
			11: g = 40'h7f49494936;
			12: g = 40'h3e41414122;
			13: g = 40'h7f4141221c;
			14: g = 40'h7f49494941;
			15: g = 40'h7f09090901;
			16: g = 40'h3e4149497a;
			17: g = 40'h7f0808087f;
			18: g = 40'h00417f4100;
			19: g = 40'h2040413f01;
			20: g = 40'h7f08142241;
			21: g = 40'h7f40404040;
			22: g = 40'h7f020c027f;
			23: g = 40'h7f0408107f;
			24: g = 40'h3e4141413e;
			25: g = 40'h7f09090906;
			26: g = 40'h3e4151215e;
			27: g = 40'h7f09192946;
			28: g = 40'h4649494931;
			29: g = 40'h01017f0101;
			30: g = 40'h3f4040403f;
			31: g = 40'h1f2040201f;
			32: g = 40'h3f4038403f;
			33: g = 40'h6314081463;
			34: g = 40'h0708700807;
			35: g = 40'h6151494543;
			36: g = 40'h0060600000;
			37: g = 40'h0080600000;
			38: g = 40'h0808080808;
			39: g = 40'h2010080402;
			default: g = 40'h0036360000;
		endcase
		return g[(4 - col) * 8 +: 8];
	endfunction

	// Color and coverage of one pixel under the current configuration.
	function automatic pixel_result_t predict_pixel(input logic [15:0] item);
		int px, py, s, len, cell_w, text_w, x0, y0, dx, dy, pos, col, row;
		logic [7:0] ch;
		logic [7:0] bits;
		pixel_result_t r;
		px = int'(item[7:0]);
		py = int'(item[11:8]);
		s = (scale_sel == SCALE_ONE) ? 1 : 2;
		len = (int'(text_len) > MAX_CHARS) ? MAX_CHARS : int'(text_len);
		cell_w = 6 * s;
		text_w = len * cell_w;
		// Signed division truncates toward zero, so x0 goes negative on wide text.
		x0 = (LINE_W - text_w) / 2;
		y0 = (LINE_H - 8 * s) / 2;
		r.lit = 1'b0;
		if (px < LINE_W && py < LINE_H) begin
			dx = px - x0;
			dy = py - y0;
			if (dx >= 0 && dx < text_w && dy >= 0 && dy < 8 * s) begin
				pos = dx / cell_w;
				col = (dx % cell_w) / s;
				row = dy / s;
				if (col < 5 && row < 8) begin
					ch = text_word[pos / 8][(pos % 8) * 8 +: 8];
					bits = font_column(ch, col);
					r.lit = bits[row];
				end
			end
		end
		r.color = r.lit ? ink : 16'h0000;
		return r;
	endfunction

	// One register write, mirrored into the bench copy.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TEXT_0_7: text_word[0] = val;
			REG_TEXT_8_15: text_word[1] = val;
			REG_TEXT_16_23: text_word[2] = val;
			REG_TEXT_24_30: text_word[3] = val & LAST_WORD_MASK;
			REG_TEXT_LENGTH: text_len = val[4:0];
			REG_INK_COLOR: ink = val[15:0];
			REG_SCALE: scale_sel = val[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Packs the staged characters into the four text registers.
	task automatic write_text();
		logic [63:0] w [TEXT_WORDS];
		for (int i = 0; i < TEXT_WORDS; i++) begin
			w[i] = '0;
		end
		for (int i = 0; i < MAX_CHARS; i++) begin
			w[i / 8][(i % 8) * 8 +: 8] = line_text[i];
		end
		// Upper byte of the last word carries junk that the block must drop.
		w[3][63:56] = 8'($urandom_range(255));
		write_reg(REG_TEXT_0_7, w[0]);
		write_reg(REG_TEXT_8_15, w[1]);
		write_reg(REG_TEXT_16_23, w[2]);
		write_reg(REG_TEXT_24_30, w[3]);
	endtask

	task automatic queue_pixel(input int x, input int y);
		pending_pixels.push_back({4'b0000, 4'(y), 8'(x)});
	endtask

	// Blocks until every queued pixel has come back and the pipeline is empty.
	task automatic wait_idle();
		while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_LATENCY + 1) @(posedge clk);
	endtask

	// Mostly glyph characters, with blanks, zero bytes and high bytes mixed in.
	function automatic logic [7:0] random_text_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			return CH_UPPER_A + 8'($urandom_range(25));
		end else if (pick < 50) begin
			return CH_DIGIT_0 + 8'($urandom_range(9));
		end else if (pick < 65) begin
			case ($urandom_range(4))
				0: return CH_PERIOD;
				1: return CH_COMMA;
				2: return CH_MINUS;
				3: return CH_SLASH;
				default: return CH_COLON;
			endcase
		end else if (pick < 75) begin
			return 8'h00;
		end
		return 8'($urandom_range(255));
	endfunction

	// Input side: feeds queued pixels and records the result each one must give.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_pixels.push_back(predict_pixel(s_axis_tdata));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_axis_tdata <= pending_pixels.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: random back-pressure and a field-by-field compare.
	always @(posedge clk) begin : result_monitor
		pixel_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected output transaction, tdata %h", m_axis_tdata);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_axis_tdata[15:0] !== want.color) begin
						$error("pixel_color expected %h actual %h", want.color,
							m_axis_tdata[15:0]);
						error_count++;
					end
					if (m_axis_tdata[16] !== want.lit) begin
						$error("pixel_lit expected %b actual %b", want.lit, m_axis_tdata[16]);
						error_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Hang guard.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int added;
		int x;
		int y;
		int run;
		int sel;
		logic [63:0] wide;
		for (int i = 0; i < TEXT_WORDS; i++) begin
			text_word[i] = '0;
		end
		text_len = '0;
		ink = INK_RESET;
		scale_sel = SCALE_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset state: empty line, every pixel black.
		queue_pixel(0, 0);
		queue_pixel(112, 8);
		queue_pixel(LINE_W - 1, LINE_H - 1);
		wait_idle();

		// Full-length line at 2x, wider than the line so both ends are clipped.
		// Digits, a zero byte, two high bytes, all punctuation, then capitals.
		for (int i = 0; i < MAX_CHARS; i++) begin
			if (i < 10) begin
				line_text[i] = CH_DIGIT_0 + 8'(i);
			end else if (i == 10) begin
				line_text[i] = 8'h00;
			end else if (i == 11) begin
				line_text[i] = 8'hff;
			end else if (i == 12) begin
				line_text[i] = 8'h80;
			end else if (i == 13) begin
				line_text[i] = CH_PERIOD;
			end else if (i == 14) begin
				line_text[i] = CH_COMMA;
			end else if (i == 15) begin
				line_text[i] = CH_MINUS;
			end else if (i == 16) begin
				line_text[i] = CH_SLASH;
			end else if (i == 17) begin
				line_text[i] = CH_COLON;
			end else begin
				line_text[i] = CH_UPPER_A + 8'(i - 18);
			end
		end
		write_text();
		write_reg(REG_TEXT_LENGTH, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_INK_COLOR, 64'h1234_5678_9abc_0001);
		write_reg(REG_SCALE, 64'h0000_0000_0000_00ff);
		// An unknown index must leave everything alone.
		write_reg(REG_UNMAPPED, 64'h0);
		queue_pixel(0, 0);
		queue_pixel(LINE_W - 1, LINE_H - 1);
		queue_pixel(0, LINE_H - 1);
		queue_pixel(LINE_W - 1, 0);
		queue_pixel(LINE_W, 7);
		queue_pixel(255, 15);
		queue_pixel(112, 7);
		queue_pixel(113, 8);
		queue_pixel(100, 3);
		wait_idle();

		// Same line at 1x, fully visible, with the remaining capitals.
		for (int i = 0; i < MAX_CHARS; i++) begin
			line_text[i] = (i < 13) ? CH_UPPER_A + 8'(i + 13) : line_text[i];
		end
		write_text();
		write_reg(REG_SCALE, {56'h0, SCALE_ONE});
		write_reg(REG_INK_COLOR, 64'h0000_0000_0000_ffff);
		queue_pixel(19, 4);
		queue_pixel(20, 5);
		queue_pixel(21, 11);
		queue_pixel(22, 3);
		queue_pixel(60, 8);
		queue_pixel(200, 6);
		queue_pixel(204, 9);
		queue_pixel(LINE_W - 1, 11);
		wait_idle();

		// Random configurations, each followed by raster runs and scattered pixels.
		for (int phase = 0; phase < CONFIG_PHASES; phase++) begin
			if (phase < CONFIG_PHASES / 3) begin
				src_idle_pct = 17;
				snk_idle_pct = 67;
			end else if (phase < 2 * CONFIG_PHASES / 3) begin
				src_idle_pct = 67;
				snk_idle_pct = 17;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end

			for (int i = 0; i < MAX_CHARS; i++) begin
				line_text[i] = random_text_byte();
			end
			write_text();

			wide = {$urandom(), $urandom()};
			sel = $urandom_range(3);
			if (sel == 0) begin
				wide[4:0] = 5'd0;
			end else if (sel == 1) begin
				wide[4:0] = 5'd31;
			end
			write_reg(REG_TEXT_LENGTH, wide);

			wide = {$urandom(), $urandom()};
			sel = $urandom_range(3);
			if (sel == 0) begin
				wide[15:0] = 16'h0000;
			end else if (sel == 1) begin
				wide[15:0] = 16'hffff;
			end
			write_reg(REG_INK_COLOR, wide);

			wide = {$urandom(), $urandom()};
			case ($urandom_range(5))
				0, 1: wide[7:0] = SCALE_ONE;
				2: wide[7:0] = 8'd2;
				3: wide[7:0] = 8'd0;
				4: wide[7:0] = 8'hff;
				default: ;
			endcase
			write_reg(REG_SCALE, wide);

			if ($urandom_range(3) == 0) begin
				write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
			end

			added = 0;
			while (added < PIXELS_PER_PHASE) begin
				if ($urandom_range(99) < 65) begin
					// Short stretch of one raster row.
					y = $urandom_range(LINE_H - 1);
					x = $urandom_range(LINE_W - 1);
					run = $urandom_range(24, 1);
					for (int k = 0; k < run && x + k < 256; k++) begin
						queue_pixel(x + k, y);
						added++;
					end
				end else begin
					queue_pixel($urandom_range(255), $urandom_range(LINE_H - 1));
					added++;
				end
			end
			wait_idle();
		end

		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (error_count == 0 && expected_pixels.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/tlgr_pkg.sv
src/tlgr_text_mem.sv
src/tlgr_pix_map.sv
src/text_line_glyph_rasterizer_unit.sv
src/tlgr_checker.sv
dv/tb.sv
